FILE: design/cgcpq_pkg.sv
// cgcpq_pkg: shared types, codes and constants of the class priority queue
// no dependencies; compile first

package cgcpq_pkg;

    // fixed field widths
    localparam int ID_W   = 16;
    localparam int CLS_W  = 2;
    localparam int CNT_W  = 16;
    localparam int BUD_W  = 16;
    localparam int STAT_W = 3;

    // configuration port
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;
    localparam int NUM_COSTS = 4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_INIT_BUDGET = 3'd0;
    localparam logic [IDX_W-1:0] REG_COST_ZERO   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COST_ONE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_COST_TWO    = 3'd3;
    localparam logic [IDX_W-1:0] REG_COST_THREE  = 3'd4;

    // register reset values
    localparam logic [BUD_W-1:0] INIT_BUDGET_RST = 16'd0;
    localparam logic [BUD_W-1:0] COST_ZERO_RST   = 16'd10;
    localparam logic [BUD_W-1:0] COST_ONE_RST    = 16'd100;
    localparam logic [BUD_W-1:0] COST_TWO_RST    = 16'd70;
    localparam logic [BUD_W-1:0] COST_THREE_RST  = 16'd50;

    // action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_PUSHED = 3'd0,
        ST_SERVED = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_SHORT  = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    // sequencer states of the top level
    typedef enum logic {
        S_IDLE,
        S_OUT
    } t_state;

    // head candidate handed along the row of cells
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] cls;
        logic [BUD_W-1:0] cost;
    } t_head;

    // command broadcast to every cell
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [ID_W-1:0]  id;
        logic [CLS_W-1:0] cls;
    } t_cmd;

    // per-cell status back to the top level
    typedef struct packed {
        logic             push_done;
        logic [CNT_W-1:0] count;
    } t_cell_stat;

endpackage

FILE: design/cgcpq_in_if.sv
// cgcpq_in_if: request channel of the class priority queue (valid/ready)
// depends on cgcpq_pkg

interface cgcpq_in_if;
    import cgcpq_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [ID_W-1:0]  entry_id;
    logic [CLS_W-1:0] entry_class;

    modport source (output valid, output action, output entry_id, output entry_class,
                    input ready);
    modport sink   (input valid, input action, input entry_id, input entry_class,
                    output ready);
endinterface

FILE: design/cgcpq_out_if.sv
// cgcpq_out_if: result channel of the class priority queue (valid/ready)
// depends on cgcpq_pkg

interface cgcpq_out_if;
    import cgcpq_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   served_id;
    logic [BUD_W-1:0]  served_amount;
    logic              head_valid;
    logic [ID_W-1:0]   head_id;
    logic [CLS_W-1:0]  head_class;
    logic [BUD_W-1:0]  budget_left;
    logic [CNT_W-1:0]  served_count_zero;
    logic [CNT_W-1:0]  served_count_one;
    logic [CNT_W-1:0]  served_count_two;
    logic [CNT_W-1:0]  served_count_three;

    modport source (output valid, output status, output served_id, output served_amount,
                    output head_valid, output head_id, output head_class,
                    output budget_left, output served_count_zero, output served_count_one,
                    output served_count_two, output served_count_three,
                    input ready);
    modport sink   (input valid, input status, input served_id, input served_amount,
                    input head_valid, input head_id, input head_class,
                    input budget_left, input served_count_zero, input served_count_one,
                    input served_count_two, input served_count_three,
                    output ready);
endinterface

FILE: design/cgcpq_cell.sv
// cgcpq_cell: one class of the queue: fifo memory, pointers, fill and service count
// depends on cgcpq_pkg; a row of these cells forms the head search chain

module cgcpq_cell #(
    parameter int CLASS_DEPTH = 16,
    parameter int CELL_IDX    = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cgcpq_pkg::t_cmd        i_cmd,
    input  logic [15:0]            i_cost,
    input  cgcpq_pkg::t_head       i_head,
    output cgcpq_pkg::t_head       o_head,
    output cgcpq_pkg::t_cell_stat  o_stat
);
    import cgcpq_pkg::*;

    localparam int PTR_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
    localparam int FILL_W = $clog2(CLASS_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(CLASS_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(CLASS_DEPTH);
    localparam logic [CLS_W-1:0]  MY_CLS    = CLS_W'(CELL_IDX);
    localparam bit                REACHABLE = CELL_IDX < (1 << CLS_W);

    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ID_W-1:0]   r_mem [CLASS_DEPTH];
    logic [ID_W-1:0]   r_rd_data;

    logic is_head;
    logic push_en;
    logic pop_en;

    // this cell owns the head when it holds an entry and no lower class does
    assign is_head = (r_fill != '0) && !i_head.valid;
    assign push_en = i_cmd.push && REACHABLE && (i_cmd.cls == MY_CLS) && (r_fill != FILL_MAX);
    assign pop_en  = i_cmd.pop && is_head;

    // pointer, fill and saturating count updates
    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_fill   = r_fill;
        n_count  = r_count;
        if (push_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            n_fill   = r_fill + 1'b1;
        end
        if (pop_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            n_fill   = r_fill - 1'b1;
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_fill   <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_fill   <= n_fill;
            r_count  <= n_count;
        end
    end

    // fifo memory, read at the next read pointer with write bypass
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= i_cmd.id;
        end
        if (push_en && (r_wr_ptr == n_rd_ptr)) begin
            r_rd_data <= i_cmd.id;
        end else begin
            r_rd_data <= r_mem[n_rd_ptr];
        end
    end

    // hand the head candidate on to the next cell
    always_comb begin
        if (is_head) begin
            o_head.valid = 1'b1;
            o_head.id    = r_rd_data;
            o_head.cls   = MY_CLS;
            o_head.cost  = i_cost;
        end else begin
            o_head = i_head;
        end
    end

    assign o_stat.push_done = push_en;
    assign o_stat.count     = r_count;

endmodule

FILE: design/credit_gated_class_priority_queue.sv
// credit_gated_class_priority_queue: top level of the class priority queue
// depends on cgcpq_pkg, cgcpq_in_if, cgcpq_out_if and cgcpq_cell
//
// Usage
// - request channel i_in (valid/ready): action 0 pushes entry_id into class
//   entry_class, action 1 pops the head (oldest entry of the lowest non-empty
//   class) if the budget covers that class's cost
// - result channel o_out (valid/ready): one result item per request with
//   status, served entry, head after the step, budget and service counts
// - APB port: register 0 loads the budget, registers 1..4 set class costs
// Timing
// - one request at a time: the accept cycle updates a cell and its fifo memory,
//   state S_OUT then reads the new head through the row of cells into the output
//   register; the registered fifo memory read makes the S_OUT step necessary
// - result valid once S_OUT has loaded the output register, which it does when
//   that register is empty or its waiting result is being taken
// - the next request is taken while a result still waits in the output
//   register; a stalled receiver holds the block after that request
// Reset
// - clears all classes, the counts and the budget; costs return to defaults

module credit_gated_class_priority_queue #(
    parameter int CLASS_DEPTH = 16,
    parameter int NUM_CLASSES = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cgcpq_in_if.sink                       i_in,
    cgcpq_out_if.source                    o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cgcpq_pkg::ADDR_W-1:0]   paddr,
    input  logic [cgcpq_pkg::DATA_W-1:0]   pwdata,
    output logic [cgcpq_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import cgcpq_pkg::*;

    // configuration registers
    logic [BUD_W-1:0] r_init_budget;
    logic [BUD_W-1:0] r_cost [NUM_COSTS];
    logic [BUD_W-1:0] r_budget;
    logic [IDX_W-1:0] cfg_idx;
    logic             cfg_wr;

    // sequencer and result
    t_state           r_state, n_state;
    logic             load_out;
    logic             in_acc;
    t_status          status;
    t_status          r_status;
    logic [ID_W-1:0]  r_served_id;
    logic [BUD_W-1:0] r_served_amount;
    logic             r_out_valid;

    // cell row
    t_cmd             cmd;
    t_head            w_head [NUM_CLASSES+1];
    t_cell_stat       w_stat [NUM_CLASSES];
    logic [BUD_W-1:0] w_cost [NUM_CLASSES];
    logic [CNT_W-1:0] w_cnt  [NUM_COSTS];
    t_head            tail;
    logic             push_ok;
    logic             budget_ok;

    // apb access
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_budget <= INIT_BUDGET_RST;
            r_cost[0]     <= COST_ZERO_RST;
            r_cost[1]     <= COST_ONE_RST;
            r_cost[2]     <= COST_TWO_RST;
            r_cost[3]     <= COST_THREE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INIT_BUDGET: r_init_budget <= pwdata[BUD_W-1:0];
                REG_COST_ZERO:   r_cost[0]     <= pwdata[BUD_W-1:0];
                REG_COST_ONE:    r_cost[1]     <= pwdata[BUD_W-1:0];
                REG_COST_TWO:    r_cost[2]     <= pwdata[BUD_W-1:0];
                REG_COST_THREE:  r_cost[3]     <= pwdata[BUD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INIT_BUDGET: prdata = DATA_W'(r_init_budget);
            REG_COST_ZERO:   prdata = DATA_W'(r_cost[0]);
            REG_COST_ONE:    prdata = DATA_W'(r_cost[1]);
            REG_COST_TWO:    prdata = DATA_W'(r_cost[2]);
            REG_COST_THREE:  prdata = DATA_W'(r_cost[3]);
            default:         prdata = '0;
        endcase
    end

    // row of class cells, head search runs from class zero upward
    assign w_head[0] = '0;

    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
        if (g < NUM_COSTS) begin : g_cost
            assign w_cost[g] = r_cost[g];
        end else begin : g_nocost
            assign w_cost[g] = '0;
        end

        cgcpq_cell #(
            .CLASS_DEPTH (CLASS_DEPTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_cost  (w_cost[g]),
            .i_head  (w_head[g]),
            .o_head  (w_head[g+1]),
            .o_stat  (w_stat[g])
        );
    end

    for (genvar c = 0; c < NUM_COSTS; c++) begin : g_cnt
        if (c < NUM_CLASSES) begin : g_used
            assign w_cnt[c] = w_stat[c].count;
        end else begin : g_unused
            assign w_cnt[c] = '0;
        end
    end

    assign tail      = w_head[NUM_CLASSES];
    assign budget_ok = r_budget >= tail.cost;

    always_comb begin
        push_ok = 1'b0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            push_ok = push_ok | w_stat[k].push_done;
        end
    end

    // request decode
    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && (r_state == S_IDLE);

    assign cmd.push = in_acc && (i_in.action == ACT_PUSH);
    assign cmd.pop  = in_acc && (i_in.action == ACT_POP) && tail.valid && budget_ok;
    assign cmd.id   = i_in.entry_id;
    assign cmd.cls  = i_in.entry_class;

    always_comb begin
        priority if (i_in.action == ACT_PUSH) begin
            status = push_ok ? ST_PUSHED : ST_FULL;
        end else if (!tail.valid) begin
            status = ST_EMPTY;
        end else if (!budget_ok) begin
            status = ST_SHORT;
        end else begin
            status = ST_SERVED;
        end
    end

    // budget: loaded by register write, debited on service
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= INIT_BUDGET_RST;
        end else if (cfg_wr && (cfg_idx == REG_INIT_BUDGET)) begin
            r_budget <= pwdata[BUD_W-1:0];
        end else if (cmd.pop) begin
            r_budget <= r_budget - tail.cost;
        end
    end

    // outcome of the accepted item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status        <= status;
            r_served_id     <= cmd.pop ? tail.id : '0;
            r_served_amount <= cmd.pop ? tail.cost : '0;
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register, head taken after the cells have settled
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_out.status             <= r_status;
            o_out.served_id          <= r_served_id;
            o_out.served_amount      <= r_served_amount;
            o_out.head_valid         <= tail.valid;
            o_out.head_id            <= tail.id;
            o_out.head_class         <= tail.cls;
            o_out.budget_left        <= r_budget;
            o_out.served_count_zero  <= w_cnt[0];
            o_out.served_count_one   <= w_cnt[1];
            o_out.served_count_two   <= w_cnt[2];
            o_out.served_count_three <= w_cnt[3];
        end
    end

    assign o_out.valid = r_out_valid;

endmodule

FILE: design/cgcpq_checker.sv
// cgcpq_port_checker: port-level checks of the class priority queue, bound to the top
// depends on cgcpq_pkg and credit_gated_class_priority_queue

module cgcpq_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [15:0] i_served_id,
    input logic [15:0] i_served_amount,
    input logic        i_head_valid,
    input logic [15:0] i_head_id,
    input logic [1:0]  i_head_class
);
    import cgcpq_pkg::*;

    // one item in work at a time: no accept right after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted in the cycle after an accept");

    // nothing served means no served id and no debit
    a_no_serve_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_SERVED)) |-> (i_served_id == '0 && i_served_amount == '0))
        else $error("served fields set on a result that served nothing");

    // an empty head reads as zero
    a_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_head_valid) |-> (i_head_id == '0 && i_head_class == '0))
        else $error("head fields set while no head is valid");

    // an empty pop leaves the queue empty
    a_empty_no_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_EMPTY)) |-> !i_head_valid)
        else $error("empty result reports a head");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_served_id) && $stable(i_head_id)))
        else $error("result changed while stalled");

endmodule

bind credit_gated_class_priority_queue cgcpq_port_checker u_cgcpq_port_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.status),
    .i_served_id     (o_out.served_id),
    .i_served_amount (o_out.served_amount),
    .i_head_valid    (o_out.head_valid),
    .i_head_id       (o_out.head_id),
    .i_head_class    (o_out.head_class)
);

FILE: dv/cgcpq_checker.sv
// cgcpq_checker: scoreboard for the class priority queue; tracks register writes
// and request items, predicts each result item and compares it field by field
// depends on cgcpq_pkg, cgcpq_in_if and cgcpq_out_if

module cgcpq_checker
    import cgcpq_pkg::*;
#(
    parameter int CLASS_DEPTH = 16,
    parameter int NUM_CLASSES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cgcpq_in_if               in_ch,
    cgcpq_out_if              out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                o_err_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // one predicted result item
    typedef struct packed {
        t_status               status;
        logic [ID_W-1:0]       served_id;
        logic [BUD_W-1:0]      served_amount;
        logic                  head_valid;
        logic [ID_W-1:0]       head_id;
        logic [CLS_W-1:0]      head_class;
        logic [BUD_W-1:0]      budget_left;
        logic [3:0][CNT_W-1:0] served_cnt;
    } t_result;

    // shadow copy of the queue state and registers
    logic [ID_W-1:0]  ent_mem [NUM_CLASSES][CLASS_DEPTH];
    int               rd_ptr [NUM_CLASSES];
    int               wr_ptr [NUM_CLASSES];
    int               fill [NUM_CLASSES];
    logic [BUD_W-1:0] budget;
    logic [BUD_W-1:0] cost [NUM_COSTS];
    logic [CNT_W-1:0] served_cnt [NUM_CLASSES];

    t_result          expected_results [$];
    t_result          exp_r;
    int               err_count = 0;

    // lowest class holding an entry, NUM_CLASSES when all are empty
    function automatic int lowest_class();
        for (int c = 0; c < NUM_CLASSES; c++)
            if (fill[c] != 0) return c;
        return NUM_CLASSES;
    endfunction

    // apply one request item to the shadow state and build its result
    function automatic t_result predict_queue_result(input logic act,
                                                     input logic [ID_W-1:0] id,
                                                     input logic [CLS_W-1:0] cls);
        t_result          r;
        int               h;
        logic [BUD_W-1:0] debit;
        r = '0;
        if (act == ACT_PUSH) begin
            if (int'(cls) >= NUM_CLASSES || fill[cls] >= CLASS_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                ent_mem[cls][wr_ptr[cls]] = id;
                wr_ptr[cls] = (wr_ptr[cls] + 1) % CLASS_DEPTH;
                fill[cls]++;
                r.status = ST_PUSHED;
            end
        end else begin
            h = lowest_class();
            debit = (h < NUM_COSTS) ? cost[h] : '0;
            if (h >= NUM_CLASSES) begin
                r.status = ST_EMPTY;
            end else if (budget < debit) begin
                r.status = ST_SHORT;
            end else begin
                r.status        = ST_SERVED;
                r.served_id     = ent_mem[h][rd_ptr[h]];
                r.served_amount = debit;
                budget          = budget - debit;
                rd_ptr[h]       = (rd_ptr[h] + 1) % CLASS_DEPTH;
                fill[h]--;
                if (served_cnt[h] != '1) served_cnt[h]++;
            end
        end
        // head after the step
        h = lowest_class();
        if (h < NUM_CLASSES) begin
            r.head_valid = 1'b1;
            r.head_id    = ent_mem[h][rd_ptr[h]];
            r.head_class = CLS_W'(h);
        end
        r.budget_left = budget;
        for (int c = 0; c < 4; c++)
            r.served_cnt[c] = (c < NUM_CLASSES) ? served_cnt[c] : '0;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, fname, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset state of the queue
            for (int c = 0; c < NUM_CLASSES; c++) begin
                rd_ptr[c]     = 0;
                wr_ptr[c]     = 0;
                fill[c]       = 0;
                served_cnt[c] = '0;
            end
            budget  = INIT_BUDGET_RST;
            cost[0] = COST_ZERO_RST;
            cost[1] = COST_ONE_RST;
            cost[2] = COST_TWO_RST;
            cost[3] = COST_THREE_RST;
            expected_results.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_INIT_BUDGET: budget  = pwdata[BUD_W-1:0];
                    REG_COST_ZERO:   cost[0] = pwdata[BUD_W-1:0];
                    REG_COST_ONE:    cost[1] = pwdata[BUD_W-1:0];
                    REG_COST_TWO:    cost[2] = pwdata[BUD_W-1:0];
                    REG_COST_THREE:  cost[3] = pwdata[BUD_W-1:0];
                    default: ;
                endcase
            end
            // result item against the oldest prediction
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result item with nothing expected, status %0h",
                             $time, out_ch.status);
                    err_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(out_ch.status));
                    check_field("served_id", 32'(exp_r.served_id), 32'(out_ch.served_id));
                    check_field("served_amount", 32'(exp_r.served_amount),
                                32'(out_ch.served_amount));
                    check_field("head_valid", 32'(exp_r.head_valid), 32'(out_ch.head_valid));
                    check_field("head_id", 32'(exp_r.head_id), 32'(out_ch.head_id));
                    check_field("head_class", 32'(exp_r.head_class), 32'(out_ch.head_class));
                    check_field("budget_left", 32'(exp_r.budget_left),
                                32'(out_ch.budget_left));
                    check_field("served_count_zero", 32'(exp_r.served_cnt[0]),
                                32'(out_ch.served_count_zero));
                    check_field("served_count_one", 32'(exp_r.served_cnt[1]),
                                32'(out_ch.served_count_one));
                    check_field("served_count_two", 32'(exp_r.served_cnt[2]),
                                32'(out_ch.served_count_two));
                    check_field("served_count_three", 32'(exp_r.served_cnt[3]),
                                32'(out_ch.served_count_three));
                end
            end
            // request item
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(predict_queue_result(in_ch.action, in_ch.entry_id,
                                                                in_ch.entry_class));
        end
        o_err_count <= err_count;
        o_pending   <= expected_results.size();
    end

endmodule

FILE: dv/credit_gated_class_priority_queue_tb.sv
// credit_gated_class_priority_queue_tb: drives requests, result stalls and register
// writes into the class priority queue and reports the verdict of the checker
// depends on cgcpq_pkg, cgcpq_in_if, cgcpq_out_if, cgcpq_checker and the block

module credit_gated_class_priority_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cgcpq_pkg::*;

    localparam int CLASS_DEPTH   = 16;
    localparam int NUM_CLASSES   = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 178;
    localparam int DRAIN_WAIT    = 4;
    localparam int CYCLE_LIMIT   = 400000;

    // addresses past the last register
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                err_count;
    int                exp_pending;
    int                cycle_cnt = 0;
    bit                tx_calm = 1'b0;

    cgcpq_in_if  in_ch ();
    cgcpq_out_if out_ch ();

    credit_gated_class_priority_queue #(
        .CLASS_DEPTH(CLASS_DEPTH),
        .NUM_CLASSES(NUM_CLASSES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cgcpq_checker #(
        .CLASS_DEPTH(CLASS_DEPTH),
        .NUM_CLASSES(NUM_CLASSES)
    ) u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .o_err_count (err_count),
        .o_pending   (exp_pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("credit_gated_class_priority_queue: mismatch");
            $finish;
        end
    end

    // gap length: mostly none, often short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BUD_W-1:0] pick_cost(input int phase);
        int r;
        if (phase == 0) return '0;
        if (phase == 1) return '1;
        r = $urandom_range(0, 9);
        if (r < 2) return '0;
        if (r < 3) return '1;
        if (r < 8) return BUD_W'($urandom_range(1, 200));
        return BUD_W'($urandom);
    endfunction

    function automatic logic [BUD_W-1:0] pick_budget(input int phase);
        int r;
        if (phase == 1) return '1;
        r = $urandom_range(0, 9);
        if (r < 4) return '1;
        if (r < 5) return '0;
        if (r < 8) return BUD_W'($urandom_range(0, 3000));
        return BUD_W'($urandom);
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return ID_W'($urandom);
    endfunction

    // present one request item and hold it until accepted
    task automatic send_item(input logic act, input logic [ID_W-1:0] id,
                             input logic [CLS_W-1:0] cls);
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.entry_id    <= id;
        in_ch.entry_class <= cls;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic idle_pause(input int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result item
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (exp_pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // setup and access phases, then an idle phase with psel low
    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [BUD_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side stalls, with calm stretches
    initial begin : rx_stall
        int  stall_left;
        int  seg_left;
        bit  calm;
        int  n;
        stall_left = 0;
        seg_left   = 0;
        calm       = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 300);
                calm     = ($urandom_range(0, 3) == 0);
            end else begin
                seg_left--;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                n = calm ? 0 : pick_gap();
                if (n > 0) begin
                    out_ch.ready <= 1'b0;
                    stall_left = n - 1;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial begin : stimulus
        int               push_pct;
        logic [CLS_W-1:0] fav_cls;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_PUSH;
        in_ch.entry_id    <= '0;
        in_ch.entry_class <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_rst_n           <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: pop on empty queue, then pop with too little budget
        send_item(ACT_POP, 16'h5A5A, 2'd1);
        send_item(ACT_PUSH, 16'hFFFF, 2'd3);
        send_item(ACT_PUSH, 16'h0000, 2'd0);
        send_item(ACT_POP, 16'h0000, 2'd0);
        drain_results();

        // budget load, writes to addresses past the last register
        apb_write(REG_INIT_BUDGET, 16'hFFFF);
        apb_write(REG_SPARE_LO, 16'hFFFF);
        apb_write(REG_SPARE_HI, 16'h1234);
        send_item(ACT_POP, 16'hFFFF, 2'd3);

        // fill class two to its depth and one more
        for (int k = 0; k <= CLASS_DEPTH; k++)
            send_item(ACT_PUSH, ID_W'(16'h2000 + k), 2'd2);
        drain_results();

        // zero cost serve, top cost on class three
        apb_write(REG_COST_TWO, 16'h0000);
        apb_write(REG_COST_THREE, 16'hFFFF);
        send_item(ACT_POP, 16'h0001, 2'd0);
        send_item(ACT_PUSH, 16'h8001, 2'd2);

        // random phases, each with its own costs, budget and push mix
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            apb_write(REG_COST_ZERO, pick_cost(p));
            apb_write(REG_COST_ONE, pick_cost(p));
            apb_write(REG_COST_TWO, pick_cost(p));
            apb_write(REG_COST_THREE, pick_cost(p));
            apb_write(REG_INIT_BUDGET, pick_budget(p));
            push_pct = $urandom_range(25, 75);
            fav_cls  = CLS_W'($urandom_range(0, 3));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 60 == 0) tx_calm = ($urandom_range(0, 3) == 0);
                // occasional full drain and budget reload mid phase
                if ($urandom_range(0, 199) == 0) begin
                    drain_results();
                    apb_write(REG_INIT_BUDGET, pick_budget(p));
                end
                if ($urandom_range(0, 99) < push_pct)
                    send_item(ACT_PUSH, pick_id(),
                              $urandom_range(0, 1) ? fav_cls : CLS_W'($urandom_range(0, 3)));
                else
                    send_item(ACT_POP, ID_W'($urandom), CLS_W'($urandom));
                idle_pause(tx_calm ? 0 : pick_gap());
            end
        end
        drain_results();

        // verdict
        if (err_count == 0) begin
            $display("credit_gated_class_priority_queue: match");
        end else begin
            $display("credit_gated_class_priority_queue: mismatch");
        end
        $finish;
    end

endmodule

FILE: credit_gated_class_priority_queue.f
design/cgcpq_pkg.sv
design/cgcpq_in_if.sv
design/cgcpq_out_if.sv
design/cgcpq_cell.sv
design/credit_gated_class_priority_queue.sv
design/cgcpq_checker.sv
dv/cgcpq_checker.sv
dv/credit_gated_class_priority_queue_tb.sv
